// File: rtl/u8d_pkg.sv
// Shared types, constants and functions of the UTF-8 stream decoder.
// Used by u8d_front, u8d_back, utf8_stream_decoder and tb; depends on nothing.
package u8d_pkg;

    // Byte classes, worked out as a byte enters the queue and again on replay.
    typedef logic [2:0] t_cls;
    localparam t_cls CLS_ASCII = 3'd0;
    localparam t_cls CLS_BAD   = 3'd1;
    localparam t_cls CLS_LEAD2 = 3'd2;
    localparam t_cls CLS_LEAD3 = 3'd3;
    localparam t_cls CLS_LEAD4 = 3'd4;

    localparam logic [20:0] CP_REPL    = 21'h00FFFD;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [20:0] CP_MIN2    = 21'h000080;
    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_MIN4    = 21'h010000;

    localparam logic [7:0] MASK_ASCII = 8'h80;
    localparam logic [7:0] MASK_L2    = 8'hE0;
    localparam logic [7:0] MASK_L3    = 8'hF0;
    localparam logic [7:0] MASK_L4    = 8'hF8;
    localparam logic [7:0] PAT_L2     = 8'hC0;
    localparam logic [7:0] PAT_L3     = 8'hE0;
    localparam logic [7:0] PAT_L4     = 8'hF0;
    localparam logic [1:0] PAT_CONT   = 2'b10;

    localparam int QDEPTH = 2;

    // One queued word: the raw byte, its end mark and its class.
    typedef struct packed {
        logic [7:0] data;
        logic       last_byte;
        t_cls       cls;
    } t_qent;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_head;

    // One decoded result.
    typedef struct packed {
        logic [20:0] cp;
        logic        rep;
    } t_res;

    typedef struct packed {
        logic        ok;
        logic [20:0] cp;
    } t_judge;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        if ((b & MASK_ASCII) == 8'h00)      c = CLS_ASCII;
        else if ((b & MASK_L2) == PAT_L2)   c = CLS_LEAD2;
        else if ((b & MASK_L3) == PAT_L3)   c = CLS_LEAD3;
        else if ((b & MASK_L4) == PAT_L4)   c = CLS_LEAD4;
        else                                c = CLS_BAD;
        return c;
    endfunction

    // Judges a complete sequence: the buffered bytes and the closing byte.
    function automatic t_judge judge(input logic [7:0] p0, input logic [7:0] p1,
                                     input logic [7:0] p2, input logic [7:0] b,
                                     input logic [2:0] len);
        t_judge      j;
        logic [20:0] cp;
        logic [20:0] min_cp;
        logic        cont_ok;
        cp      = '0;
        min_cp  = '0;
        cont_ok = 1'b0;
        case (len)
            3'd2: begin
                cp      = {10'd0, p0[4:0], b[5:0]};
                min_cp  = CP_MIN2;
                cont_ok = (b[7:6] == PAT_CONT);
            end
            3'd3: begin
                cp      = {5'd0, p0[3:0], p1[5:0], b[5:0]};
                min_cp  = CP_MIN3;
                cont_ok = (p1[7:6] == PAT_CONT) && (b[7:6] == PAT_CONT);
            end
            3'd4: begin
                cp      = {p0[2:0], p1[5:0], p2[5:0], b[5:0]};
                min_cp  = CP_MIN4;
                cont_ok = (p1[7:6] == PAT_CONT) && (p2[7:6] == PAT_CONT)
                          && (b[7:6] == PAT_CONT);
            end
            default: begin
                cont_ok = 1'b0;
            end
        endcase
        j.cp = cp;
        j.ok = cont_ok && (cp >= min_cp) && (cp <= CP_MAX)
               && !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
        return j;
    endfunction

endpackage

// File: rtl/u8d_front.sv
// Front end of the UTF-8 stream decoder: accepts bytes, classifies them and
// holds them in a two-word queue for the back end. Depends on u8d_pkg.
module u8d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_stream_end,
    output u8d_pkg::t_head  o_head,
    input  logic            i_pop
);

    u8d_pkg::t_qent r_q [u8d_pkg::QDEPTH];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    logic           push;

    assign o_in_ready = (r_count < 2'(u8d_pkg::QDEPTH));
    assign push       = i_in_valid && o_in_ready;

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.ent   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr].data      <= i_data_byte;
            r_q[r_wptr].last_byte <= i_stream_end;
            r_q[r_wptr].cls       <= u8d_pkg::classify(i_data_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/u8d_back.sv
// Back end of the UTF-8 stream decoder: sequence buffer, replay of bytes
// after a bad sequence, result holding and output register. Depends on u8d_pkg.
module u8d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u8d_pkg::t_head  i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [20:0]     o_code_point,
    output logic            o_is_replacement,
    output logic            o_run_last,
    output logic            o_stream_done
);

    // Sequence buffer and replay queue.
    logic [7:0]       r_pb [3];
    logic [7:0]       n_pb [3];
    logic [1:0]       r_cnt, n_cnt;
    logic [2:0]       r_elen, n_elen;
    logic [7:0]       r_rq [3];
    logic [7:0]       n_rq [3];
    logic [1:0]       r_rlen, n_rlen;
    logic             r_flush, n_flush;
    logic             r_close, n_close;
    logic             r_cur_end, n_cur_end;
    // Held result, waiting to learn whether it is the last of its word.
    logic             r_h_valid, n_h_valid;
    u8d_pkg::t_res    r_h, n_h;
    // Output register.
    logic             r_out_valid, n_out_valid;
    u8d_pkg::t_res    r_out, n_out;
    logic             r_out_last, n_out_last;
    logic             r_out_done, n_out_done;

    logic             adv;
    logic             step_close, step_replay, step_flush, step_fresh;
    logic [7:0]       cur_byte;
    u8d_pkg::t_cls    cur_cls;
    logic             end_flag;
    logic [1:0]       rem_len;
    u8d_pkg::t_judge  jdg;
    logic             res_valid;
    u8d_pkg::t_res    res;
    logic             fin;

    always_comb begin
        adv         = !r_out_valid || i_out_ready;
        step_close  = r_close;
        step_replay = !r_close && (r_rlen != 2'd0);
        step_flush  = !r_close && (r_rlen == 2'd0) && r_flush;
        step_fresh  = !r_close && (r_rlen == 2'd0) && !r_flush && i_head.valid;
        cur_byte    = step_replay ? r_rq[0] : i_head.ent.data;
        cur_cls     = step_replay ? u8d_pkg::classify(r_rq[0]) : i_head.ent.cls;
        end_flag    = step_fresh ? i_head.ent.last_byte : r_cur_end;
        rem_len     = step_replay ? (r_rlen - 2'd1) : 2'd0;
        jdg         = u8d_pkg::judge(r_pb[0], r_pb[1], r_pb[2], cur_byte, r_elen);

        n_pb      = r_pb;
        n_cnt     = r_cnt;
        n_elen    = r_elen;
        n_rq[0]   = r_rq[1];
        n_rq[1]   = r_rq[2];
        n_rq[2]   = r_rq[2];
        n_rlen    = r_rlen;
        n_flush   = r_flush;
        n_close   = r_close;
        n_cur_end = r_cur_end;
        n_h_valid = r_h_valid;
        n_h       = r_h;
        res_valid = 1'b0;
        res       = '{cp: '0, rep: 1'b0};
        fin       = 1'b0;

        if (step_flush) begin
            res_valid = 1'b1;
            res       = '{cp: u8d_pkg::CP_REPL, rep: 1'b1};
            n_cnt     = 2'd0;
            n_elen    = 3'd0;
            n_flush   = 1'b0;
            fin       = 1'b1;
        end else if (step_replay || step_fresh) begin
            n_rlen = rem_len;
            if (step_fresh) begin
                n_cur_end = i_head.ent.last_byte;
            end
            if (r_cnt == 2'd0) begin
                case (cur_cls)
                    u8d_pkg::CLS_ASCII: begin
                        res_valid = 1'b1;
                        res       = '{cp: {13'd0, cur_byte}, rep: 1'b0};
                    end
                    u8d_pkg::CLS_LEAD2: begin
                        n_pb[0] = cur_byte;
                        n_cnt   = 2'd1;
                        n_elen  = 3'd2;
                    end
                    u8d_pkg::CLS_LEAD3: begin
                        n_pb[0] = cur_byte;
                        n_cnt   = 2'd1;
                        n_elen  = 3'd3;
                    end
                    u8d_pkg::CLS_LEAD4: begin
                        n_pb[0] = cur_byte;
                        n_cnt   = 2'd1;
                        n_elen  = 3'd4;
                    end
                    default: begin
                        res_valid = 1'b1;
                        res       = '{cp: u8d_pkg::CP_REPL, rep: 1'b1};
                    end
                endcase
            end else if (({1'b0, r_cnt} + 3'd1) < r_elen) begin
                n_pb[r_cnt] = cur_byte;
                n_cnt       = r_cnt + 2'd1;
            end else begin
                n_cnt     = 2'd0;
                n_elen    = 3'd0;
                res_valid = 1'b1;
                if (jdg.ok) begin
                    res = '{cp: jdg.cp, rep: 1'b0};
                end else begin
                    // Drop the lead byte and scan its followers again, ahead
                    // of whatever replay bytes were still waiting.
                    res     = '{cp: u8d_pkg::CP_REPL, rep: 1'b1};
                    n_rq[0] = (r_cnt == 2'd1) ? cur_byte : r_pb[1];
                    n_rq[1] = (r_cnt == 2'd1) ? r_rq[1] :
                              (r_cnt == 2'd2) ? cur_byte : r_pb[2];
                    n_rq[2] = (r_cnt == 2'd1) ? r_rq[2] :
                              (r_cnt == 2'd2) ? r_rq[1] : cur_byte;
                    n_rlen  = r_cnt + rem_len;
                end
            end
            if (end_flag && (n_rlen == 2'd0) && (n_cnt != 2'd0)) begin
                n_flush = 1'b1;
            end
            fin = (n_rlen == 2'd0) && !(end_flag && (n_cnt != 2'd0));
        end

        n_out_valid = 1'b0;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        if (step_close) begin
            n_out_valid = 1'b1;
            n_out       = r_h;
            n_out_last  = 1'b1;
            n_out_done  = r_cur_end;
            n_h_valid   = 1'b0;
            n_close     = 1'b0;
        end else if (r_h_valid && res_valid) begin
            n_out_valid = 1'b1;
            n_out       = r_h;
            n_out_last  = 1'b0;
            n_out_done  = 1'b0;
            n_h         = res;
            n_close     = fin;
        end else if (r_h_valid && fin) begin
            n_out_valid = 1'b1;
            n_out       = r_h;
            n_out_last  = 1'b1;
            n_out_done  = end_flag;
            n_h_valid   = 1'b0;
        end else if (res_valid && fin) begin
            n_out_valid = 1'b1;
            n_out       = res;
            n_out_last  = 1'b1;
            n_out_done  = end_flag;
        end else if (res_valid) begin
            n_h       = res;
            n_h_valid = 1'b1;
        end
    end

    assign o_pop = adv && step_fresh;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pb <= n_pb;
            r_rq <= n_rq;
            r_h  <= n_h;
            if (n_out_valid) begin
                r_out      <= n_out;
                r_out_last <= n_out_last;
                r_out_done <= n_out_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 2'd0;
            r_elen      <= 3'd0;
            r_rlen      <= 2'd0;
            r_flush     <= 1'b0;
            r_close     <= 1'b0;
            r_cur_end   <= 1'b0;
            r_h_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_cnt       <= n_cnt;
            r_elen      <= n_elen;
            r_rlen      <= n_rlen;
            r_flush     <= n_flush;
            r_close     <= n_close;
            r_cur_end   <= n_cur_end;
            r_h_valid   <= n_h_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_code_point     = r_out.cp;
    assign o_is_replacement = r_out.rep;
    assign o_run_last       = r_out_last;
    assign o_stream_done    = r_out_done;

endmodule

// File: rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder, top level: front end queue plus decoding back end.
// Depends on u8d_pkg, u8d_front and u8d_back.
//
// Usage: raw bytes enter on the input channel (i_in_valid / o_in_ready) with
// i_stream_end marking the final byte of a stream. Code points leave on the
// output channel (o_out_valid / i_out_ready), one word per result. Replacement
// code points (U+FFFD) for malformed input carry o_is_replacement. Each input
// byte gives zero or more results; o_run_last marks the last result of a
// byte, and o_stream_done marks the final result of a stream.
// An accepted byte is registered in the queue, and its first result is then
// registered in the output register, from which the receiver takes it.
// Throughput: one byte per cycle for well-formed input while the receiver
// keeps up, set by the single-byte step of the back end; a stalled receiver
// holds the back end. The following bytes of a sequence judged bad are
// scanned again; a byte whose last result comes while an earlier one is still
// held needs a further closing step, and a stream that ends inside a sequence
// needs a step of its own for its closing replacement.
// The two-word queue lets the front keep taking bytes while the back end
// works or the receiver stalls; when it is full, o_in_ready falls. The output
// is registered, so a stalled receiver holds the word steady.
// Reset (synchronous, active low) empties the queue, the sequence buffer and
// the output register.
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_code_point,
    output logic        o_is_replacement,
    output logic        o_run_last,
    output logic        o_stream_done
);

    // Queue head and pop strobe between the front and back ends.
    u8d_pkg::t_head head;
    logic           pop;

    u8d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_head       (head),
        .i_pop        (pop)
    );

    u8d_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_code_point     (o_code_point),
        .o_is_replacement (o_is_replacement),
        .o_run_last       (o_run_last),
        .o_stream_done    (o_stream_done)
    );

`ifndef ASSERT_OFF
    // The back end only takes a word that the queue actually holds.
    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    // The end of a stream always closes the run of its last byte.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_done) |-> o_run_last)
        else $error("stream end flagged on a result that is not last");

    // Error results always carry the replacement character.
    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_replacement) |-> (o_code_point == u8d_pkg::CP_REPL))
        else $error("error result without U+FFFD");

    // Decoded values are scalar values: in range and never a surrogate.
    a_scalar_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_code_point <= u8d_pkg::CP_MAX)
            && !((o_code_point >= u8d_pkg::CP_SURR_LO)
                 && (o_code_point <= u8d_pkg::CP_SURR_HI))))
        else $error("result is not a Unicode scalar value");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the UTF-8 stream decoder utf8_stream_decoder.
// Holds its own bytewise decoder as predictor; depends on u8d_pkg and the RTL.
// Directed corner bytes first, then random streams, under random idling on both sides.
`timescale 1ns / 1ps

module tb;

    // One byte waiting to be offered, with its end mark. When hold_first is
    // set, the byte is not offered until every expected code point has come.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       hold_first;
    } t_byte_item;

    // One decoded word as the block should give it.
    typedef struct packed {
        logic [20:0] cp;
        logic        rep;
        logic        last;
        logic        done;
    } t_cp_word;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_stream_end     = 1'b0;
    logic        i_out_ready      = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [20:0] o_code_point;
    logic        o_is_replacement;
    logic        o_run_last;
    logic        o_stream_done;

    utf8_stream_decoder u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_stream_end     (i_stream_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_code_point     (o_code_point),
        .o_is_replacement (o_is_replacement),
        .o_run_last       (o_run_last),
        .o_stream_done    (o_stream_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Byte source, expected code points and bookkeeping.
    t_byte_item src_bytes [$];
    t_cp_word   pending_cps [$];
    logic [7:0] unit_q [$];
    int         n_total       = 0;
    int         n_sent        = 0;
    int         n_outstanding = 0;
    int         n_fail        = 0;
    int         n_words       = 0;
    int         n_repl        = 0;
    int         n_streams     = 0;

    // Predictor state: the open sequence, its fill level and announced length.
    logic [3:0][7:0] seq_buf = '0;
    logic [2:0]      seq_cnt = 3'd0;
    logic [2:0]      seq_len = 3'd0;
    t_cp_word        step_out [4];
    int              step_n;

    function automatic void note_fail(input string msg);
        n_fail++;
        if (n_fail <= 10)
            $display("%s", msg);
    endfunction

    // Sequence length announced by a lead byte, zero for anything else.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        if (b[7:5] == 3'b110)
            return 3'd2;
        if (b[7:4] == 4'b1110)
            return 3'd3;
        if (b[7:3] == 5'b11110)
            return 3'd4;
        return 3'd0;
    endfunction

    // Assembles a complete buffered sequence and says whether it is a legal
    // scalar value: proper followers, shortest form, no surrogate, in range.
    function automatic logic seq_value(input logic [3:0][7:0] sb, input logic [2:0] len,
                                       output logic [20:0] cp);
        logic [20:0] v;
        logic [20:0] lo;
        logic        ok;
        int          k;
        ok = 1'b1;
        case (len)
            3'd2: begin
                v  = {16'd0, sb[0][4:0]};
                lo = u8d_pkg::CP_MIN2;
            end
            3'd3: begin
                v  = {17'd0, sb[0][3:0]};
                lo = u8d_pkg::CP_MIN3;
            end
            3'd4: begin
                v  = {18'd0, sb[0][2:0]};
                lo = u8d_pkg::CP_MIN4;
            end
            default: begin
                v  = '0;
                lo = '0;
                ok = 1'b0;
            end
        endcase
        for (k = 1; k < len; k++) begin
            if (sb[k][7:6] != 2'b10)
                ok = 1'b0;
            v = (v << 6) | {15'd0, sb[k][5:0]};
        end
        if (v < lo || v > u8d_pkg::CP_MAX ||
            (v >= u8d_pkg::CP_SURR_LO && v <= u8d_pkg::CP_SURR_HI))
            ok = 1'b0;
        cp = v;
        return ok;
    endfunction

    function automatic void emit(input logic [20:0] cp, input logic rep);
        if (step_n < 4) begin
            step_out[step_n] = '{cp: cp, rep: rep, last: 1'b0, done: 1'b0};
            step_n++;
        end
    endfunction

    // Decodes one accepted byte and queues the code points it gives. A bad
    // sequence gives one replacement for its lead, and the bytes buffered
    // behind the lead are scanned again ahead of anything later.
    function automatic void decode_step(input logic [7:0] b, input logic end_mark);
        logic [3:0][7:0] scan;
        logic [3:0][7:0] rest;
        logic [7:0]      c;
        logic [20:0]     v;
        int              slen;
        int              spos;
        int              rn;
        int              k;
        scan    = '0;
        scan[0] = b;
        slen    = 1;
        spos    = 0;
        step_n  = 0;
        if (seq_cnt > 3 || seq_len < 2 || seq_len > 4 || seq_cnt >= seq_len) begin
            if (seq_cnt != 0) begin
                seq_cnt = 3'd0;
                seq_len = 3'd0;
            end
        end
        while (spos < slen) begin
            c = scan[spos];
            spos++;
            if (seq_cnt == 0) begin
                if (!c[7]) begin
                    emit({13'd0, c}, 1'b0);
                end else if (lead_len(c) == 0) begin
                    emit(u8d_pkg::CP_REPL, 1'b1);
                end else begin
                    seq_buf[0] = c;
                    seq_cnt    = 3'd1;
                    seq_len    = lead_len(c);
                end
            end else begin
                seq_buf[seq_cnt[1:0]] = c;
                seq_cnt++;
                if (seq_cnt >= seq_len) begin
                    if (seq_value(seq_buf, seq_len, v)) begin
                        emit(v, 1'b0);
                    end else begin
                        emit(u8d_pkg::CP_REPL, 1'b1);
                        rest = '0;
                        rn   = 0;
                        for (k = 1; k < seq_cnt && rn < 4; k++) begin
                            rest[rn] = seq_buf[k];
                            rn++;
                        end
                        for (k = spos; k < slen && rn < 4; k++) begin
                            rest[rn] = scan[k];
                            rn++;
                        end
                        scan = rest;
                        slen = rn;
                        spos = 0;
                    end
                    seq_cnt = 3'd0;
                    seq_len = 3'd0;
                end
            end
        end
        // The stream closing inside a sequence drops what is buffered.
        if (end_mark) begin
            if (seq_cnt != 0)
                emit(u8d_pkg::CP_REPL, 1'b1);
            seq_cnt = 3'd0;
            seq_len = 3'd0;
        end
        if (step_n > 0) begin
            step_out[step_n - 1].last = 1'b1;
            step_out[step_n - 1].done = end_mark;
        end
        for (k = 0; k < step_n; k++)
            pending_cps.insert(pending_cps.size(), step_out[k]);
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers.
    // ---------------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b, input logic fin);
        src_bytes.insert(src_bytes.size(), '{data: b, fin: fin, hold_first: 1'b0});
    endfunction

    // Appends one byte to the scratch unit.
    function automatic void add_unit(input logic [7:0] b);
        unit_q.insert(unit_q.size(), b);
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Well-formed encoding of one scalar value into the scratch unit.
    function automatic void add_char(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_unit(cp[7:0]);
        end else if (cp < 21'h800) begin
            add_unit({3'b110, cp[10:6]});
            add_unit({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            add_unit({4'b1110, cp[15:12]});
            add_unit({2'b10, cp[11:6]});
            add_unit({2'b10, cp[5:0]});
        end else begin
            add_unit({5'b11110, cp[20:18]});
            add_unit({2'b10, cp[17:12]});
            add_unit({2'b10, cp[11:6]});
            add_unit({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] pick_scalar();
        logic [20:0] cp;
        int          sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0: cp = 21'h000080;
            1: cp = 21'h0007FF;
            2: cp = 21'h000800;
            3: cp = 21'h00D7FF;
            4: cp = 21'h00E000;
            5: cp = u8d_pkg::CP_REPL;
            6: cp = 21'h00FFFF;
            7: cp = 21'h010000;
            8: cp = u8d_pkg::CP_MAX;
            9: cp = 21'($urandom_range(21'h80, 21'h7FF));
            10: cp = 21'($urandom_range(21'h800, 21'hFFFF));
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        if (cp >= u8d_pkg::CP_SURR_LO && cp <= u8d_pkg::CP_SURR_HI)
            cp = cp - 21'h800;
        return cp;
    endfunction

    // Moves the scratch unit into the byte source. Mostly a stream closes on
    // the last byte of a unit, now and then in the middle of a sequence.
    function automatic void flush_unit(input logic hold_first);
        int cut;
        int k;
        logic closing;
        cut     = ($urandom_range(0, 19) == 0) ? $urandom_range(0, unit_q.size() - 1) : -1;
        closing = ($urandom_range(0, 7) == 0);
        for (k = 0; k < unit_q.size(); k++)
            src_bytes.insert(src_bytes.size(),
                             '{data: unit_q[k],
                               fin: (k == cut) || (closing && k == unit_q.size() - 1),
                               hold_first: hold_first && (k == 0)});
        unit_q.delete();
    endfunction

    // Sequences whose value is illegal although the bit pattern looks right,
    // and lone bytes that can never start a sequence.
    function automatic void add_bad_value();
        int sel;
        sel = $urandom_range(0, 6);
        case (sel)
            0: begin
                add_unit({7'b1100000, 1'($urandom_range(0, 1))});
                add_unit(cont_byte());
            end
            1: begin
                add_unit(8'hE0);
                add_unit({3'b100, 5'($urandom_range(0, 31))});
                add_unit(cont_byte());
            end
            2: begin
                add_unit(8'hED);
                add_unit({3'b101, 5'($urandom_range(0, 31))});
                add_unit(cont_byte());
            end
            3: begin
                add_unit(8'hF0);
                add_unit({4'b1000, 4'($urandom_range(0, 15))});
                add_unit(cont_byte());
                add_unit(cont_byte());
            end
            4: begin
                add_unit(8'hF4);
                add_unit(8'($urandom_range(8'h90, 8'hBF)));
                add_unit(cont_byte());
                add_unit(cont_byte());
            end
            5: begin
                add_unit(8'($urandom_range(8'hF5, 8'hF7)));
                add_unit(cont_byte());
                add_unit(cont_byte());
                add_unit(cont_byte());
            end
            default: begin
                add_unit($urandom_range(0, 1) ? 8'($urandom_range(8'hF8, 8'hFF))
                                              : cont_byte());
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Driver: offers bytes in bursts with random gaps between them. Once a
    // byte is offered it stays on the port until the block takes it.
    // ---------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 1;

    always @(posedge i_clk) begin : driver
        logic       go;
        t_byte_item it;
        go = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid)
                n_sent <= n_sent + 1;
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end else if (src_bytes.size() != 0) begin
                // A marked byte waits for an idle cycle with nothing left to
                // come, so the block has drained completely before it starts.
                if (!src_bytes[0].hold_first || (!i_in_valid && n_outstanding == 0))
                    go = 1'b1;
            end
            if (go) begin
                it = src_bytes.pop_front();
                i_data_byte  <= it.data;
                i_stream_end <= it.fin;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    if ($urandom_range(0, 2) == 0)
                        gap_left <= 0;
                    else if ($urandom_range(0, 9) == 0)
                        gap_left <= $urandom_range(10, 25);
                    else
                        gap_left <= $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
            i_in_valid <= go;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: ready follows one of several patterns, each kept for a
    // random stretch. A separate process holds it off for a long stretch
    // once, while the sender keeps offering, so the queue fills and the
    // input stalls.
    // ---------------------------------------------------------------------
    int rx_mode   = 0;
    int mode_left = 0;
    int rx_tick   = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin : hold_off
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_sent >= 80) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : receiver
        logic r;
        if (mode_left == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            mode_left <= $urandom_range(30, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: r = 1'b1;
            1: r = ($urandom_range(0, 3) != 0);
            2: r = ($urandom_range(0, 3) == 0);
            default: r = ((rx_tick % 5) < 2);
        endcase
        i_out_ready <= r && (hold_left == 0);
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each word taken from the block against the oldest
    // expectation, then predicts the words of any byte taken at this edge.
    // A byte's first word passes through the queue and the output register before
    // it shows, so checking before predicting loses nothing.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_cp_word want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_words++;
                if (o_is_replacement)
                    n_repl++;
                if (o_stream_done)
                    n_streams++;
                if (pending_cps.size() == 0) begin
                    note_fail($sformatf({"tb: word cp=%06h rep=%b last=%b done=%b",
                                         " with none expected"},
                                        o_code_point, o_is_replacement, o_run_last,
                                        o_stream_done));
                end else begin
                    want = pending_cps.pop_front();
                    if (o_code_point !== want.cp || o_is_replacement !== want.rep ||
                        o_run_last !== want.last || o_stream_done !== want.done)
                        note_fail($sformatf({"tb: word %0d expected cp=%06h rep=%b",
                                             " last=%b done=%b,",
                                             " got cp=%06h rep=%b last=%b done=%b"},
                                            n_words, want.cp, want.rep, want.last, want.done,
                                            o_code_point, o_is_replacement, o_run_last,
                                            o_stream_done));
                end
            end
            if (i_in_valid && o_in_ready)
                decode_step(i_data_byte, i_stream_end);
        end
        n_outstanding <= pending_cps.size();
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run.
    // ---------------------------------------------------------------------
    initial begin : stimulus
        int n_directed;
        int kind;
        int pos;
        logic [7:0] b;

        // ASCII extremes.
        put_byte(8'h00, 1'b0);
        put_byte(8'h7F, 1'b0);
        // Shortest two-byte value and the top four-byte value.
        put_byte(8'hC2, 1'b0); put_byte(8'h80, 1'b0);
        put_byte(8'hF4, 1'b0); put_byte(8'h8F, 1'b0); put_byte(8'hBF, 1'b0);
        put_byte(8'hBF, 1'b0);
        // A properly encoded U+FFFD is no error.
        put_byte(8'hEF, 1'b0); put_byte(8'hBF, 1'b0); put_byte(8'hBD, 1'b0);
        // Lone bytes that cannot start a sequence.
        put_byte(8'h80, 1'b0);
        put_byte(8'hFF, 1'b0);
        // Overlong two-byte form: one replacement, then the follower on its own.
        put_byte(8'hC0, 1'b0); put_byte(8'h80, 1'b0);
        // Surrogate, then a value above the top of the range.
        put_byte(8'hED, 1'b0); put_byte(8'hA0, 1'b0); put_byte(8'h80, 1'b0);
        put_byte(8'hF4, 1'b0); put_byte(8'h90, 1'b0); put_byte(8'h80, 1'b0);
        put_byte(8'h80, 1'b0);
        // Bad follower found only at full length: the rest is scanned again.
        put_byte(8'hE2, 1'b0); put_byte(8'h82, 1'b0); put_byte(8'h41, 1'b0);
        // Stream closing inside a sequence, with ASCII buffered as a bad follower
        // behind the lead, and then a fresh stream that closes on plain ASCII.
        put_byte(8'hE2, 1'b0); put_byte(8'h41, 1'b1);
        put_byte(8'h5A, 1'b1);
        n_directed = src_bytes.size();

        // Random part: mostly well-formed text, some broken and illegal
        // sequences, some raw noise.
        while (src_bytes.size() < 210) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                add_unit(8'($urandom_range(0, 127)));
            end else if (kind < 65) begin
                add_char(pick_scalar());
            end else if (kind < 77) begin
                add_char(21'($urandom_range(21'h80, 21'h10FFFF)) | 21'h800);
                if ($urandom_range(0, 1)) begin
                    pos = $urandom_range(1, unit_q.size() - 1);
                    b = 8'($urandom_range(0, 255));
                    if (b[7:6] == 2'b10)
                        b[6] = 1'b1;
                    unit_q[pos] = b;
                end else begin
                    void'(unit_q.pop_back());
                end
            end else if (kind < 89) begin
                add_bad_value();
            end else begin
                add_unit(8'($urandom_range(0, 255)));
            end
            flush_unit(src_bytes.size() == n_directed || $urandom_range(0, 39) == 0);
        end
        n_total = src_bytes.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_total)
            @(posedge i_clk);
        while (n_outstanding != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (pending_cps.size() != 0)
            note_fail($sformatf("tb: %0d expected words never came", pending_cps.size()));
        $display("tb: %0d bytes (%0d directed) gave %0d code points, %0d of them replacements,",
                 n_sent, n_directed, n_words, n_repl);
        $display("tb: %0d streams closed, %0d failures", n_streams, n_fail);
        if (n_fail == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder.sv
tb/tb.sv
